/* rtl/dcpl_pkg.sv */
// Shared widths, constants and register indexes of the DC blocker and peak limiter.
`timescale 1ns / 1ps

package dcpl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 24;
  localparam int THR_W     = 23;
  localparam int Y_W       = 28;
  localparam int ENV_W     = 28;
  localparam int GAIN_W    = 25;
  localparam int COEF_FRAC = 24;
  localparam int OUT_SHIFT = 22;

  localparam int MUL_A_W     = 29;
  localparam int MUL_B_W     = 25;
  localparam int MUL_P_W     = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_STEPS   = MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

  localparam int DIV_Q_W     = GAIN_W;
  localparam int DIV_D_W     = ENV_W + 2;
  localparam int DIV_N_W     = THR_W + COEF_FRAC + 1;
  localparam int DIV_STEPS   = DIV_Q_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DC_COEFFICIENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_DECAY  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SLEW     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SLEW    = CFG_IDX_W'(4);

  localparam logic [COEF_W-1:0] DC_COEFFICIENT_RST  = COEF_W'(16733340);
  localparam logic [COEF_W-1:0] ENVELOPE_DECAY_RST  = COEF_W'(16770505);
  localparam logic [THR_W-1:0]  LIMIT_THRESHOLD_RST = THR_W'(3858760);
  localparam logic [COEF_W-1:0] ATTACK_SLEW_RST     = COEF_W'(587203);
  localparam logic [COEF_W-1:0] RELEASE_SLEW_RST    = COEF_W'(25166);

  localparam logic [GAIN_W-1:0]      GAIN_ONE = GAIN_W'(25'h1000000);
  localparam logic [ENV_W-1:0]       ENV_MAX  = ENV_W'(28'h8000000);
  localparam logic signed [Y_W-1:0]  Y_MAX    = 28'sh7FFFFFF;
  localparam logic signed [Y_W-1:0]  Y_MIN    = 28'sh8000000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sd4194304;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sd4194304;

endpackage

/* rtl/dcpl_in_if.sv */
// Input sample channel: valid, ready and the input sample.
`timescale 1ns / 1ps

interface dcpl_in_if;
  import dcpl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* rtl/dcpl_out_if.sv */
// Output sample channel: valid, ready and the limited sample.
`timescale 1ns / 1ps

interface dcpl_out_if;
  import dcpl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/dcpl_serial_mul.sv */
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module dcpl_serial_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [dcpl_pkg::MUL_A_W-1:0] a,
  input  logic [dcpl_pkg::MUL_B_W-1:0]        b,
  output logic                               busy,
  output logic signed [dcpl_pkg::MUL_P_W-1:0] prod
);
  import dcpl_pkg::*;

  logic                      busy_q;
  logic [MUL_CNT_W-1:0]      cnt;
  logic signed [MUL_A_W-1:0] mcand;
  logic [MUL_B_W-1:0]        mplier;
  logic signed [MUL_A_W:0]   hi;
  logic [MUL_B_W-1:0]        lo;
  logic signed [MUL_A_W:0]   sum;

  always_comb begin
    sum = hi + (mplier[0] ? (MUL_A_W + 1)'(mcand) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      cnt    <= MUL_CNT_W'(MUL_STEPS);
    end else if (busy_q) begin
      cnt <= cnt - MUL_CNT_W'(1);
      if (cnt == MUL_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      hi     <= '0;
      lo     <= '0;
    end else if (busy_q) begin
      hi     <= {sum[MUL_A_W], sum[MUL_A_W:1]};
      lo     <= {sum[0], lo[MUL_B_W-1:1]};
      mplier <= mplier >> 1;
    end
  end

  assign busy = busy_q;
  assign prod = {hi, lo};

endmodule

/* rtl/dcpl_serial_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps

module dcpl_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dcpl_pkg::DIV_N_W-1:0] num,
  input  logic [dcpl_pkg::DIV_D_W-1:0] den,
  output logic                        busy,
  output logic [dcpl_pkg::DIV_Q_W-1:0] quo
);
  import dcpl_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_Q_W-1:0]   nsh;
  logic [DIV_Q_W-1:0]   q;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  always_comb begin
    trial = {rem, nsh[DIV_Q_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      cnt    <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
      nsh   <= num[DIV_Q_W-1:0];
      den_q <= den;
      q     <= '0;
    end else if (busy_q) begin
      rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      nsh <= nsh << 1;
      q   <= {q[DIV_Q_W-2:0], ge};
    end
  end

  assign busy = busy_q;
  assign quo  = q;

endmodule

/* rtl/dc_blocker_peak_limiter_unit.sv */
// Each sample runs in sequence: the DC-blocker feedback multiply and the envelope decay
// multiply side by side, a restoring divide for threshold/envelope (only when the envelope
// is above the threshold), the gain slew multiply and the output gain multiply. A new sample
// is taken only in idle, after the last result is loaded; an output stall holds it off.
// Reset (rst, synchronous): registers to defaults, filter state zero, gain 1.0, output empty.
`timescale 1ns / 1ps

module dc_blocker_peak_limiter_unit (
  input  logic                          clk,
  input  logic                          rst,
  dcpl_in_if.sink                       din,
  dcpl_out_if.source                    dout,
  input  logic                          cfg_write_enable,
  input  logic [dcpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcpl_pkg::CFG_W-1:0]     cfg_data
);
  import dcpl_pkg::*;

  localparam int RND_W = MUL_P_W - COEF_FRAC;
  localparam int OUT_RND_W = MUL_P_W - OUT_SHIFT;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BLK   = 9'b000000010,
    S_TGT   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SLEW  = 9'b000010000,
    S_MSLEW = 9'b000100000,
    S_OMUL  = 9'b001000000,
    S_MOUT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [COEF_W-1:0] dc_coefficient;
  logic [COEF_W-1:0] envelope_decay;
  logic [THR_W-1:0]  limit_threshold;
  logic [COEF_W-1:0] attack_slew;
  logic [COEF_W-1:0] release_slew;

  logic signed [SAMPLE_W-1:0] dc_last_input;
  logic signed [Y_W-1:0]      dc_last_output;
  logic [ENV_W-1:0]           peak_envelope;
  logic [GAIN_W-1:0]          limiter_gain;
  logic [GAIN_W-1:0]          target_gain;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic signed [OUT_W-1:0]    result;
  logic                       out_valid;

  logic                       accept;
  logic                       load_out;

  logic                       mul0_start, mul0_busy;
  logic signed [MUL_A_W-1:0]  mul0_a;
  logic [MUL_B_W-1:0]         mul0_b;
  logic signed [MUL_P_W-1:0]  mul0_p;
  logic                       mul1_busy;
  logic signed [MUL_P_W-1:0]  mul1_p;

  logic                       div_start, div_busy;
  logic [DIV_N_W-1:0]         div_num;
  logic [DIV_D_W-1:0]         div_den;
  logic [DIV_Q_W-1:0]         div_quo;

  logic signed [RND_W-1:0]     fb_rnd;
  logic signed [31:0]          y_sum;
  logic signed [Y_W-1:0]       y_new;
  logic [ENV_W-1:0]            y_mag;
  logic signed [RND_W-1:0]     dec_rnd;
  logic [ENV_W-1:0]            decayed;
  logic [ENV_W-1:0]            env_new;
  logic                        over;
  logic [GAIN_W-1:0]           quo_cap;
  logic signed [GAIN_W:0]      gain_diff;
  logic                        falling;
  logic signed [RND_W-1:0]     delta;
  logic signed [31:0]          gain_sum;
  logic [GAIN_W-1:0]           gain_new;
  logic signed [OUT_RND_W-1:0] o_rnd;
  logic signed [OUT_W-1:0]     o_new;

  assign accept   = din.valid && din.ready;
  assign din.ready = (state == S_IDLE);
  assign load_out = (state == S_FIN) && (!out_valid || dout.ready);
  assign dout.valid = out_valid;
  assign dout.sample_out = result;

  dcpl_serial_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul0_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .busy  (mul0_busy),
    .prod  (mul0_p)
  );

  dcpl_serial_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (MUL_A_W'({1'b0, peak_envelope})),
    .b     (MUL_B_W'(envelope_decay)),
    .busy  (mul1_busy),
    .prod  (mul1_p)
  );

  dcpl_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // datapath
  always_comb begin
    fb_rnd  = mul0_p[MUL_P_W-1:COEF_FRAC] + RND_W'(mul0_p[COEF_FRAC-1]);
    y_sum   = 32'(sample_hold) - 32'(dc_last_input) + 32'(fb_rnd);
    if (y_sum > 32'(Y_MAX)) begin
      y_new = Y_MAX;
    end else if (y_sum < 32'(Y_MIN)) begin
      y_new = Y_MIN;
    end else begin
      y_new = y_sum[Y_W-1:0];
    end
    y_mag   = y_new[Y_W-1] ? ENV_W'(-y_new) : ENV_W'(y_new);
    dec_rnd = mul1_p[MUL_P_W-1:COEF_FRAC] + RND_W'(mul1_p[COEF_FRAC-1]);
    decayed = dec_rnd[ENV_W-1:0];
    env_new = (y_mag > decayed) ? y_mag : decayed;

    div_den = {peak_envelope, 2'b00};
    over    = div_den > DIV_D_W'(limit_threshold);
    div_num = (DIV_N_W'(limit_threshold) << COEF_FRAC) + (DIV_N_W'(peak_envelope) << 1);
    quo_cap = (div_quo > GAIN_ONE) ? GAIN_ONE : div_quo;

    gain_diff = $signed({1'b0, target_gain}) - $signed({1'b0, limiter_gain});
    falling   = target_gain < limiter_gain;

    delta    = mul0_p[MUL_P_W-1:COEF_FRAC] + RND_W'(mul0_p[COEF_FRAC-1]);
    gain_sum = 32'($signed({1'b0, limiter_gain})) + 32'(delta);
    if (gain_sum < 32'sd0) begin
      gain_new = '0;
    end else if (gain_sum > 32'($signed({1'b0, GAIN_ONE}))) begin
      gain_new = GAIN_ONE;
    end else begin
      gain_new = gain_sum[GAIN_W-1:0];
    end

    o_rnd = mul0_p[MUL_P_W-1:OUT_SHIFT] + OUT_RND_W'(mul0_p[OUT_SHIFT-1]);
    if (o_rnd > OUT_RND_W'(OUT_MAX)) begin
      o_new = OUT_MAX;
    end else if (o_rnd < OUT_RND_W'(OUT_MIN)) begin
      o_new = OUT_MIN;
    end else begin
      o_new = o_rnd[OUT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mul0_start = 1'b0;
    mul0_a     = '0;
    mul0_b     = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        mul0_a = MUL_A_W'(dc_last_output);
        mul0_b = MUL_B_W'(dc_coefficient);
        if (accept) begin
          mul0_start = 1'b1;
          state_next = S_BLK;
        end
      end
      S_BLK: begin
        if (!mul0_busy && !mul1_busy) begin
          state_next = S_TGT;
        end
      end
      S_TGT: begin
        if (over) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_SLEW;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_SLEW;
        end
      end
      S_SLEW: begin
        mul0_start = 1'b1;
        mul0_a     = MUL_A_W'(gain_diff);
        mul0_b     = MUL_B_W'(falling ? attack_slew : release_slew);
        state_next = S_MSLEW;
      end
      S_MSLEW: begin
        if (!mul0_busy) begin
          state_next = S_OMUL;
        end
      end
      S_OMUL: begin
        mul0_start = 1'b1;
        mul0_a     = MUL_A_W'(dc_last_output);
        mul0_b     = MUL_B_W'(limiter_gain);
        state_next = S_MOUT;
      end
      S_MOUT: begin
        if (!mul0_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      dc_coefficient  <= DC_COEFFICIENT_RST;
      envelope_decay  <= ENVELOPE_DECAY_RST;
      limit_threshold <= LIMIT_THRESHOLD_RST;
      attack_slew     <= ATTACK_SLEW_RST;
      release_slew    <= RELEASE_SLEW_RST;
      dc_last_input   <= '0;
      dc_last_output  <= '0;
      peak_envelope   <= '0;
      limiter_gain    <= GAIN_ONE;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_enable) begin
        unique case (cfg_index)
          REG_DC_COEFFICIENT:  dc_coefficient  <= cfg_data[COEF_W-1:0];
          REG_ENVELOPE_DECAY:  envelope_decay  <= cfg_data[COEF_W-1:0];
          REG_LIMIT_THRESHOLD: limit_threshold <= cfg_data[THR_W-1:0];
          REG_ATTACK_SLEW:     attack_slew     <= cfg_data[COEF_W-1:0];
          REG_RELEASE_SLEW:    release_slew    <= cfg_data[COEF_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == S_BLK && !mul0_busy && !mul1_busy) begin
        dc_last_input  <= sample_hold;
        dc_last_output <= y_new;
        peak_envelope  <= env_new;
      end
      if (state == S_MSLEW && !mul0_busy) begin
        limiter_gain <= gain_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= din.sample_in;
    end
    if (state == S_TGT && !over) begin
      target_gain <= GAIN_ONE;
    end else if (state == S_DIV && !div_busy) begin
      target_gain <= quo_cap;
    end
    if (load_out) begin
      result <= o_new;
    end
  end

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    limiter_gain <= GAIN_ONE)
    else $error("limiter gain above unity");

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    peak_envelope <= ENV_MAX)
    else $error("peak envelope out of range");

  a_units_free: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !mul0_busy && !mul1_busy && !div_busy)
    else $error("input ready while an arithmetic unit is busy");

  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> mul0_busy && mul1_busy)
    else $error("multipliers not started on input transfer");

endmodule
